### rtl/kme_pkg.sv
package kme_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_EDGES_DEF    = 64;
    localparam int WEIGHT_BITS      = 24;
    localparam int TOTAL_BITS       = 28;
    localparam int MAX_TREE_EDGES   = 15;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_EDGE   = 2'd2;
    localparam logic [1:0] KIND_TOTAL  = 2'd3;

    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_EDGE_LIMIT   = 2'd1;

    typedef struct packed {
        logic [1:0]                    cmd;
        logic [3:0]                    vertex_a;
        logic [3:0]                    vertex_b;
        logic signed [WEIGHT_BITS-1:0] edge_weight;
    } req_t;

    typedef struct packed {
        logic [1:0]                    kind;
        logic                          error;
        logic [3:0]                    end_a;
        logic [3:0]                    end_b;
        logic signed [WEIGHT_BITS-1:0] weight_out;
        logic signed [TOTAL_BITS-1:0]  total_weight;
        logic                          last;
    } rsp_t;

    typedef struct packed {
        logic [3:0]                    end_b;
        logic [3:0]                    end_a;
        logic signed [WEIGHT_BITS-1:0] weight;
    } edge_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_LK_RD,
        S_LK_CHK,
        S_LK_EMIT,
        S_CLR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIND_A_RD,
        S_FIND_A_CHK,
        S_FIND_B_RD,
        S_FIND_B_CHK,
        S_DECIDE,
        S_EMIT_EDGE,
        S_TOTAL
    } state_t;

endpackage

### rtl/kme_edge_mem.sv
module kme_edge_mem
    import kme_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF,
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  edge_t         wdata,
    input  logic [AW-1:0] raddr,
    output edge_t         rdata
);

    edge_t mem [MAX_EDGES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/kme_parent_mem.sv
module kme_parent_mem
    import kme_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int VW = $clog2(MAX_VERTICES)
)(
    input  logic          clk,
    input  logic          we,
    input  logic [VW-1:0] waddr,
    input  logic [VW-1:0] wdata,
    input  logic [VW-1:0] raddr,
    output logic [VW-1:0] rdata
);

    logic [VW-1:0] mem [MAX_VERTICES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/kruskal_mst_engine_core.sv
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_stall | req (req_t)
// rsp     | out | rsp_valid / rsp_stall | rsp (rsp_t)
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// Insert writes the edge memory and then acks. Lookup scans the n stored edges until a match.
// Run: resets all MAX_VERTICES entries of the parent memory, then per visited edge
// a scan over the edge memory plus a walk over each node on each root path.
// One request is worked at a time; req_stall is low only in idle.
// rst_n clears control state; memory contents stay undefined until written.
// A stalled rsp holds the engine in its emit state.
module kruskal_mst_engine_core
    import kme_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int IW = (CW > VW) ? CW : VW;
    localparam logic [CW-1:0] EDGES_MAX = CW'(MAX_EDGES);
    localparam logic [IW-1:0] VTX_LAST  = IW'(MAX_VERTICES - 1);
    localparam logic signed [TOTAL_BITS:0] SUM_MAX = (TOTAL_BITS+1)'(2**(TOTAL_BITS-1) - 1);
    localparam logic signed [TOTAL_BITS:0] SUM_MIN = -(TOTAL_BITS+1)'(2**(TOTAL_BITS-1));

    state_t state_reg, state_next;
    logic [CW-1:0] edge_total_reg, edge_total_next;
    logic [4:0] vcount_reg, vcount_next;
    logic [6:0] elimit_reg, elimit_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [3:0] qa_reg, qa_next, qb_reg, qb_next;
    logic err_reg, err_next;
    logic signed [WEIGHT_BITS-1:0] lw_reg, lw_next;
    logic best_found_reg, best_found_next;
    edge_t best_reg, best_next;
    logic [CW-1:0] best_idx_reg, best_idx_next;
    logic have_prev_reg, have_prev_next;
    logic signed [WEIGHT_BITS-1:0] prev_w_reg, prev_w_next;
    logic [CW-1:0] prev_idx_reg, prev_idx_next;
    logic [CW-1:0] picks_reg, picks_next;
    logic [3:0] k_reg, k_next;
    logic [VW-1:0] cur_reg, cur_next, ra_reg, ra_next;
    logic signed [TOTAL_BITS-1:0] total_reg, total_next;
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic e_we;
    logic [AW-1:0] e_waddr, e_raddr;
    edge_t e_wdata, e_rdata;
    logic p_we;
    logic [VW-1:0] p_waddr, p_wdata, p_rdata;

    logic [CW-1:0] lim;
    logic [4:0] nv;
    logic slot_free, req_acc, ins_err;
    logic [CW-1:0] idx_c;
    logic signed [TOTAL_BITS:0] sum;
    logic signed [TOTAL_BITS-1:0] sum_sat;

    kme_edge_mem #(.MAX_EDGES(MAX_EDGES)) u_edge_mem (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    kme_parent_mem #(.MAX_VERTICES(MAX_VERTICES)) u_parent_mem (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (cur_reg),
        .rdata (p_rdata)
    );

    assign lim       = (elimit_reg > 7'(MAX_EDGES)) ? EDGES_MAX : CW'(elimit_reg);
    assign nv        = (32'(vcount_reg) > MAX_VERTICES) ? 5'(MAX_VERTICES) : vcount_reg;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign ins_err   = (edge_total_reg >= lim) || (edge_total_reg >= EDGES_MAX)
                       || (5'(req.vertex_a) >= nv) || (5'(req.vertex_b) >= nv);
    assign idx_c     = CW'(idx_reg);
    assign sum       = (TOTAL_BITS+1)'(total_reg) + (TOTAL_BITS+1)'(best_reg.weight);
    assign sum_sat   = (sum > SUM_MAX) ? SUM_MAX[TOTAL_BITS-1:0]
                     : (sum < SUM_MIN) ? SUM_MIN[TOTAL_BITS-1:0] : sum[TOTAL_BITS-1:0];
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = edge_total_reg[AW-1:0];
        e_wdata = '{end_b: req.vertex_b, end_a: req.vertex_a, weight: req.edge_weight};
        e_raddr = idx_reg[AW-1:0];
        p_we    = 1'b0;
        p_waddr = ra_reg;
        p_wdata = cur_reg;
        case (state_reg)
            S_IDLE:
            begin
                e_we = req_acc && (req.cmd == CMD_INSERT) && !ins_err;
            end
            S_CLR:
            begin
                p_we    = 1'b1;
                p_waddr = idx_reg[VW-1:0];
                p_wdata = idx_reg[VW-1:0];
            end
            S_DECIDE:
            begin
                p_we = (ra_reg != cur_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        vcount_next     = vcount_reg;
        elimit_next     = elimit_reg;
        idx_next        = idx_reg;
        qa_next         = qa_reg;
        qb_next         = qb_reg;
        err_next        = err_reg;
        lw_next         = lw_reg;
        best_found_next = best_found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        have_prev_next  = have_prev_reg;
        prev_w_next     = prev_w_reg;
        prev_idx_next   = prev_idx_reg;
        picks_next      = picks_reg;
        k_next          = k_reg;
        cur_next        = cur_reg;
        ra_next         = ra_reg;
        total_next      = total_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        if (cfg_valid && cfg_index == CFG_VERTEX_COUNT)
        begin
            vcount_next = cfg_data[4:0];
        end
        if (cfg_valid && cfg_index == CFG_EDGE_LIMIT)
        begin
            elimit_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                qa_next  = req.vertex_a;
                qb_next  = req.vertex_b;
                lw_next  = '0;
                if (req_acc)
                begin
                    case (req.cmd)
                        CMD_INSERT:
                        begin
                            err_next   = ins_err;
                            state_next = S_INS;
                            if (!ins_err)
                            begin
                                edge_total_next = edge_total_reg + 1'b1;
                            end
                        end
                        CMD_LOOKUP: state_next = S_LK_RD;
                        CMD_RUN:    state_next = S_CLR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_INS:
            begin
                if (slot_free)
                begin
                    rsp_next       = '0;
                    rsp_next.kind  = KIND_ACK;
                    rsp_next.error = err_reg;
                    rsp_next.last  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LK_RD:
            begin
                state_next = (idx_c >= edge_total_reg) ? S_LK_EMIT : S_LK_CHK;
            end
            S_LK_CHK:
            begin
                if ((e_rdata.end_a == qa_reg && e_rdata.end_b == qb_reg)
                    || (e_rdata.end_a == qb_reg && e_rdata.end_b == qa_reg))
                begin
                    lw_next    = e_rdata.weight;
                    state_next = S_LK_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LK_RD;
                end
            end
            S_LK_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_next            = '0;
                    rsp_next.kind       = KIND_LOOKUP;
                    rsp_next.end_a      = qa_reg;
                    rsp_next.end_b      = qb_reg;
                    rsp_next.weight_out = lw_reg;
                    rsp_next.last       = 1'b1;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_CLR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == VTX_LAST)
                begin
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    have_prev_next  = 1'b0;
                    picks_next      = '0;
                    k_next          = '0;
                    total_next      = '0;
                    state_next      = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (idx_c >= edge_total_reg)
                begin
                    cur_next   = VW'(best_reg.end_a);
                    state_next = best_found_reg ? S_FIND_A_RD : S_TOTAL;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if ((!have_prev_reg || e_rdata.weight > prev_w_reg
                     || (e_rdata.weight == prev_w_reg && idx_c > prev_idx_reg))
                    && (!best_found_reg || e_rdata.weight < best_reg.weight))
                begin
                    best_found_next = 1'b1;
                    best_next       = e_rdata;
                    best_idx_next   = idx_c;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN_RD;
            end
            S_FIND_A_RD:
            begin
                state_next = S_FIND_A_CHK;
            end
            S_FIND_A_CHK:
            begin
                if (p_rdata == cur_reg)
                begin
                    ra_next    = cur_reg;
                    cur_next   = VW'(best_reg.end_b);
                    state_next = S_FIND_B_RD;
                end
                else
                begin
                    cur_next   = p_rdata;
                    state_next = S_FIND_A_RD;
                end
            end
            S_FIND_B_RD:
            begin
                state_next = S_FIND_B_CHK;
            end
            S_FIND_B_CHK:
            begin
                if (p_rdata == cur_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cur_next   = p_rdata;
                    state_next = S_FIND_B_RD;
                end
            end
            S_DECIDE:
            begin
                prev_w_next     = best_reg.weight;
                prev_idx_next   = best_idx_reg;
                have_prev_next  = 1'b1;
                picks_next      = picks_reg + 1'b1;
                idx_next        = '0;
                best_found_next = 1'b0;
                if (ra_reg != cur_reg)
                begin
                    total_next = sum_sat;
                    state_next = S_EMIT_EDGE;
                end
                else
                begin
                    state_next = (picks_reg + 1'b1 == edge_total_reg) ? S_TOTAL : S_SCAN_RD;
                end
            end
            S_EMIT_EDGE:
            begin
                if (slot_free)
                begin
                    rsp_next              = '0;
                    rsp_next.kind         = KIND_EDGE;
                    rsp_next.end_a        = best_reg.end_a;
                    rsp_next.end_b        = best_reg.end_b;
                    rsp_next.weight_out   = best_reg.weight;
                    rsp_next.total_weight = total_reg;
                    rsp_valid_next        = 1'b1;
                    k_next                = k_reg + 1'b1;
                    if (k_reg + 1'b1 == 4'(MAX_TREE_EDGES) || picks_reg == edge_total_reg)
                    begin
                        state_next = S_TOTAL;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_TOTAL:
            begin
                if (slot_free)
                begin
                    rsp_next              = '0;
                    rsp_next.kind         = KIND_TOTAL;
                    rsp_next.total_weight = total_reg;
                    rsp_next.last         = 1'b1;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_total_reg <= '0;
            vcount_reg     <= 5'd16;
            elimit_reg     <= 7'd64;
            rsp_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
            have_prev_reg  <= 1'b0;
            picks_reg      <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            vcount_reg     <= vcount_next;
            elimit_reg     <= elimit_next;
            rsp_valid_reg  <= rsp_valid_next;
            idx_reg        <= idx_next;
            best_found_reg <= best_found_next;
            have_prev_reg  <= have_prev_next;
            picks_reg      <= picks_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg       <= qa_next;
        qb_reg       <= qb_next;
        err_reg      <= err_next;
        lw_reg       <= lw_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        prev_w_reg   <= prev_w_next;
        prev_idx_reg <= prev_idx_next;
        cur_reg      <= cur_next;
        ra_reg       <= ra_next;
        total_reg    <= total_next;
        rsp_reg      <= rsp_next;
    end

    a_edge_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= EDGES_MAX)
        else $error("edge count above capacity");

    a_tree_edge_not_loop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.kind == KIND_EDGE |-> rsp_reg.end_a != rsp_reg.end_b)
        else $error("tree edge is a self loop");

    a_nonlast_is_edge: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.last |-> rsp_reg.kind == KIND_EDGE)
        else $error("non-final result is not a tree edge");

    a_insert_to_ack: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.cmd == CMD_INSERT |=> state_reg == S_INS)
        else $error("insert did not move to ack");

endmodule

### dv/tb_kruskal_mst_engine_core.sv
module tb_kruskal_mst_engine_core
    import kme_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    kruskal_mst_engine_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    logic [3:0]             graph_end_a[MAX_EDGES_DEF];
    logic [3:0]             graph_end_b[MAX_EDGES_DEF];
    logic signed [23:0]     graph_weight[MAX_EDGES_DEF];
    int                     graph_edges;
    int                     vertex_count_reg;
    int                     edge_limit_reg;

    logic req_taken;
    logic cfg_taken;
    bit   quiet_mode;
    int   fail_count;
    int   idle_cycles;
    int   req_gap;
    int   stall_left;
    int   n_inserts;
    int   n_refused;
    int   n_lookups;
    int   n_runs;
    int   n_tree_edges;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t make_rsp(logic [1:0] kind, logic err, logic [3:0] a,
                                      logic [3:0] b, logic signed [23:0] w,
                                      logic signed [27:0] t, logic lst);
        rsp_t r;
        r.kind         = kind;
        r.error        = err;
        r.end_a        = a;
        r.end_b        = b;
        r.weight_out   = w;
        r.total_weight = t;
        r.last         = lst;
        return r;
    endfunction

    function automatic void expect_rsp(rsp_t r);
        expected_rsps = {expected_rsps, r};
    endfunction

    function automatic void queue_req(req_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic int find_set(int parent[MAX_VERTICES_DEF], int v);
        int hops;
        for (hops = 0; hops < MAX_VERTICES_DEF && parent[v] != v; hops++)
            v = parent[v];
        return v;
    endfunction

    function automatic void predict_spanning_tree();
        int      order[MAX_EDGES_DEF];
        int      parent[MAX_VERTICES_DEF];
        int      i;
        int      j;
        int      cur;
        int      ra;
        int      rb;
        int      kept;
        longint  sum;
        kept = 0;
        sum  = 0;
        for (i = 0; i < MAX_VERTICES_DEF; i++)
            parent[i] = i;
        for (i = 0; i < graph_edges; i++)
        begin
            cur = i;
            j   = i;
            while (j > 0 && graph_weight[order[j-1]] > graph_weight[cur])
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        for (i = 0; i < graph_edges; i++)
        begin
            cur = order[i];
            ra  = find_set(parent, int'(graph_end_a[cur]));
            rb  = find_set(parent, int'(graph_end_b[cur]));
            if (ra != rb && kept < MAX_TREE_EDGES)
            begin
                parent[ra] = rb;
                sum = sum + graph_weight[cur];
                if (sum > 134217727)
                    sum = 134217727;
                if (sum < -134217728)
                    sum = -134217728;
                expect_rsp(make_rsp(KIND_EDGE, 1'b0, graph_end_a[cur],
                    graph_end_b[cur], graph_weight[cur], sum[27:0], 1'b0));
                kept++;
            end
        end
        n_tree_edges += kept;
        expect_rsp(make_rsp(KIND_TOTAL, 1'b0, 4'd0, 4'd0, 24'sd0, sum[27:0], 1'b1));
    endfunction

    function automatic void predict_request(req_t r);
        int                 nv;
        int                 lim;
        int                 i;
        logic signed [23:0] w;
        nv  = vertex_count_reg > MAX_VERTICES_DEF ? MAX_VERTICES_DEF : vertex_count_reg;
        lim = edge_limit_reg > MAX_EDGES_DEF ? MAX_EDGES_DEF : edge_limit_reg;
        case (r.cmd)
            CMD_INSERT:
            begin
                n_inserts++;
                if (graph_edges >= lim || int'(r.vertex_a) >= nv || int'(r.vertex_b) >= nv)
                begin
                    n_refused++;
                    expect_rsp(make_rsp(KIND_ACK, 1'b1, 4'd0, 4'd0,
                                        24'sd0, 28'sd0, 1'b1));
                end
                else
                begin
                    graph_end_a[graph_edges]  = r.vertex_a;
                    graph_end_b[graph_edges]  = r.vertex_b;
                    graph_weight[graph_edges] = r.edge_weight;
                    graph_edges++;
                    expect_rsp(make_rsp(KIND_ACK, 1'b0, 4'd0, 4'd0,
                                        24'sd0, 28'sd0, 1'b1));
                end
            end
            CMD_LOOKUP:
            begin
                n_lookups++;
                w = 24'sd0;
                for (i = 0; i < graph_edges; i++)
                begin
                    if ((graph_end_a[i] == r.vertex_a && graph_end_b[i] == r.vertex_b) ||
                        (graph_end_a[i] == r.vertex_b && graph_end_b[i] == r.vertex_a))
                    begin
                        w = graph_weight[i];
                        break;
                    end
                end
                expect_rsp(make_rsp(KIND_LOOKUP, 1'b0, r.vertex_a,
                                    r.vertex_b, w, 28'sd0, 1'b1));
            end
            CMD_RUN:
            begin
                n_runs++;
                predict_spanning_tree();
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endtask

    // monitor: sample handshakes and compare results
    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            cfg_taken <= 1'b0;
        end
        else
        begin
            req_taken <= req_valid && !req_stall;
            cfg_taken <= cfg_valid && cfg_ready;
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (req_valid && !req_stall)
                predict_request(req);
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got %p", $time, rsp);
                end
                else
                begin
                    exp_r = expected_rsps.pop_front();
                    check_field("kind", exp_r.kind, rsp.kind);
                    check_field("error", exp_r.error, rsp.error);
                    check_field("end_a", exp_r.end_a, rsp.end_a);
                    check_field("end_b", exp_r.end_b, rsp.end_b);
                    check_field("weight_out", exp_r.weight_out, rsp.weight_out);
                    check_field("total_weight", exp_r.total_weight, rsp.total_weight);
                    check_field("last", exp_r.last, rsp.last);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // driver: requests and result stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (!quiet_mode && $urandom_range(0, 4) == 0)
                begin
                    req_gap = $urandom_range(0, 3);
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet_mode && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    function automatic req_t make_req(logic [1:0] cmd, logic [3:0] a, logic [3:0] b,
                                      logic signed [23:0] w);
        req_t r;
        r.cmd         = cmd;
        r.vertex_a    = a;
        r.vertex_b    = b;
        r.edge_weight = w;
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [6:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        if (idx == CFG_VERTEX_COUNT)
            vertex_count_reg = int'(value[4:0]);
        else
            edge_limit_reg = int'(value);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic queue_random(int count);
        int                 k;
        int                 pick;
        int                 nv;
        int                 e;
        logic [3:0]         a;
        logic [3:0]         b;
        logic signed [23:0] w;
        nv = vertex_count_reg > 16 ? 16 : vertex_count_reg;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            a = 4'($urandom);
            b = 4'($urandom);
            w = 24'($urandom);
            if (pick < 55)
            begin
                if (nv > 0 && $urandom_range(0, 9) != 0)
                begin
                    a = 4'($urandom_range(0, nv - 1));
                    b = 4'($urandom_range(0, nv - 1));
                end
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    w = 24'((int'($urandom_range(0, 40)) - 20) * 256);
                else if (pick == 9)
                    w = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
                queue_req(make_req(CMD_INSERT, a, b, w));
            end
            else if (pick < 80)
            begin
                if (graph_edges > 0 && $urandom_range(0, 2) != 0)
                begin
                    e = $urandom_range(0, graph_edges - 1);
                    a = graph_end_a[e];
                    b = graph_end_b[e];
                    if ($urandom_range(0, 1))
                    begin
                        a = graph_end_b[e];
                        b = graph_end_a[e];
                    end
                end
                queue_req(make_req(CMD_LOOKUP, a, b, w));
            end
            else if (pick < 95)
                queue_req(make_req(CMD_RUN, a, b, w));
            else
                queue_req(make_req(2'd3, a, b, w));
        end
    endtask

    initial
    begin
        int vc_set[9];
        int lim_set[9];
        int p;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_VERTEX_COUNT;
        cfg_data    = '0;
        quiet_mode  = 1'b0;
        fail_count  = 0;
        idle_cycles = 0;
        req_gap     = 0;
        stall_left  = 0;
        graph_edges = 0;
        vertex_count_reg = 16;
        edge_limit_reg   = 64;
        n_inserts = 0;
        n_refused = 0;
        n_lookups = 0;
        n_runs    = 0;
        n_tree_edges = 0;
        vc_set  = '{4, 16, 1, 0, 31, 8, 16, 2, 16};
        lim_set = '{10, 20, 24, 30, 40, 0, 127, 50, 64};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_req(make_req(CMD_RUN, 4'd0, 4'd0, 24'sd0));
        queue_req(make_req(CMD_INSERT, 4'd0, 4'd15, 24'sh7fffff));
        queue_req(make_req(CMD_INSERT, 4'd15, 4'd1, 24'sh800000));
        queue_req(make_req(CMD_INSERT, 4'd3, 4'd3, -24'sd512));
        queue_req(make_req(CMD_INSERT, 4'd1, 4'd2, 24'sd256));
        queue_req(make_req(CMD_INSERT, 4'd2, 4'd0, 24'sd256));
        queue_req(make_req(CMD_INSERT, 4'd0, 4'd1, 24'sd0));
        queue_req(make_req(CMD_INSERT, 4'd15, 4'd0, 24'sd5));
        queue_req(make_req(CMD_LOOKUP, 4'd15, 4'd0, 24'sd0));
        queue_req(make_req(CMD_LOOKUP, 4'd3, 4'd3, 24'sd0));
        queue_req(make_req(CMD_LOOKUP, 4'd7, 4'd9, 24'sd0));
        queue_req(make_req(CMD_RUN, 4'd15, 4'd15, 24'shffffff));
        queue_req(make_req(2'd3, 4'd15, 4'd15, 24'shffffff));
        queue_req(make_req(CMD_RUN, 4'd0, 4'd0, 24'sd0));
        drain();

        for (p = 0; p < 9; p++)
        begin
            write_reg(CFG_VERTEX_COUNT, 7'(vc_set[p]));
            write_reg(CFG_EDGE_LIMIT, 7'(lim_set[p]));
            if (p == 8)
                quiet_mode = 1'b1;
            queue_random(52);
            drain();
        end

        repeat (50) @(negedge clk);
        $display("Covered %0d inserts (%0d refused), %0d lookups, %0d tree runs",
                 n_inserts, n_refused, n_lookups, n_runs);
        $display("Tree runs kept %0d edges over %0d stored edges", n_tree_edges, graph_edges);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
